>>> rtl/core/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
// Holds the transfer structs, token codes and keyword table; depends on nothing.
package stt_pkg;

   // Slots in one result bundle; one source byte yields at most three results.
   localparam int unsigned BUNDLE_SLOTS = 4;
   localparam int unsigned SLOT_W       = $clog2(BUNDLE_SLOTS);
   localparam int unsigned COUNT_W      = $clog2(BUNDLE_SLOTS + 1);
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned KW_COUNT     = 6;
   localparam int unsigned KW_MAX_TEXT  = 8;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_text;
   } stt_req_type;

   typedef struct packed {
      logic [4:0] token_type;
      logic [7:0] text_byte;
      logic       token_end;
   } stt_rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]                 count;
      stt_rsp_type [BUNDLE_SLOTS-1:0]     item;
   } stt_bundle_type;

   typedef enum logic [4:0] {
      TOK_OPEN_PAREN  = 5'd0,
      TOK_CLOSE_PAREN = 5'd1,
      TOK_ASSIGN      = 5'd2,
      TOK_EQUAL       = 5'd3,
      TOK_NOT         = 5'd4,
      TOK_NOT_EQUAL   = 5'd5,
      TOK_GREATER     = 5'd6,
      TOK_LESS        = 5'd7,
      TOK_ADD         = 5'd8,
      TOK_SUBTRACT    = 5'd9,
      TOK_MULTIPLY    = 5'd10,
      TOK_DIVIDE      = 5'd11,
      TOK_COMMA       = 5'd12,
      TOK_STRING      = 5'd13,
      TOK_INT         = 5'd14,
      TOK_IDENT       = 5'd15,
      TOK_KW_FUNCTION = 5'd16,
      TOK_KW_VARIABLE = 5'd17,
      TOK_KW_END      = 5'd18,
      TOK_KW_IF       = 5'd19,
      TOK_KW_RETURN   = 5'd20,
      TOK_KW_PRINT    = 5'd21,
      TOK_UNKNOWN_KW  = 5'd22
   } tok_kind_type;

   localparam logic [7:0] CHAR_QUOTE = 8'h22;

   // Keyword letters, letter i at index i; unused positions are zero.
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_TEXT] = '{
      '{"F", "U", "N", "C", "T", "I", "O", "N"},
      '{"V", "A", "R", "I", "A", "B", "L", "E"},
      '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"I", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"R", "E", "T", "U", "R", "N", 8'h00, 8'h00},
      '{"P", "R", "I", "N", "T", 8'h00, 8'h00, 8'h00}
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd8, 4'd8, 4'd3, 4'd2, 4'd6, 4'd5};

endpackage

>>> rtl/core/stt_front.sv
// Front end of the tokenizer: accepts source bytes, tracks the scan state and
// builds one bundle of results per byte. Depends on stt_pkg.
module stt_front #(
   parameter int unsigned MAX_KEYWORD_LEN = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  stt_pkg::stt_req_type   req_data,
   output logic                   push_valid,
   input  logic                   push_ready,
   output stt_pkg::stt_bundle_type push_data
);
   import stt_pkg::*;

   localparam int unsigned LET_W = 8 * MAX_KEYWORD_LEN;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_EQ   = 3'd1,
      MODE_BANG = 3'd2,
      MODE_STR  = 3'd3,
      MODE_INT  = 3'd4,
      MODE_KW   = 3'd5,
      MODE_ID   = 3'd6
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [LET_W-1:0] letters_ff, letters_in;
   logic [3:0]       len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             halt_ff, halt_in;
   stt_bundle_type   bundle;
   logic             do_close, do_class;
   logic [5:0]       pend;
   logic [7:0]       b;
   logic             accept;

   function automatic stt_rsp_type mk_text(input logic [7:0] ch);
      stt_rsp_type r;
      r.token_type = 5'd0;
      r.text_byte  = ch;
      r.token_end  = 1'b0;
      return r;
   endfunction

   function automatic stt_rsp_type mk_end(input logic [4:0] t);
      stt_rsp_type r;
      r.token_type = t;
      r.text_byte  = 8'd0;
      r.token_end  = 1'b1;
      return r;
   endfunction

   function automatic logic [4:0] kw_match(input logic [LET_W-1:0] let_v,
                                           input logic [3:0] len_v,
                                           input logic ovf_v);
      logic [4:0] t;
      logic       same;
      t = TOK_UNKNOWN_KW;
      if (!ovf_v) begin
         for (int k = 0; k < KW_COUNT; k++) begin
            same = (len_v == KW_LEN[k]);
            for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
               if ((i < int'(KW_LEN[k])) && (let_v[8*i +: 8] != KW_TEXT[k][i])) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               t = 5'(int'(TOK_KW_FUNCTION) + k);
            end
         end
      end
      return t;
   endfunction

   // Bit 5 says a pending token is open; bits 4:0 carry its closing type.
   function automatic logic [5:0] pend_of(input mode_type m, input logic [LET_W-1:0] let_v,
                                          input logic [3:0] len_v, input logic ovf_v);
      logic [5:0] p;
      case (m)
         MODE_EQ:   p = {1'b1, TOK_ASSIGN};
         MODE_BANG: p = {1'b1, TOK_NOT};
         MODE_STR:  p = {1'b1, TOK_STRING};
         MODE_INT:  p = {1'b1, TOK_INT};
         MODE_KW:   p = {1'b1, kw_match(let_v, len_v, ovf_v)};
         MODE_ID:   p = {1'b1, TOK_IDENT};
         default:   p = 6'd0;
      endcase
      return p;
   endfunction

   assign b          = req_data.source_byte;
   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = req_valid && (bundle.count != '0);
   assign push_data  = bundle;

   always_comb begin
      mode_in    = mode_ff;
      letters_in = letters_ff;
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      halt_in    = halt_ff;
      bundle     = '0;
      do_close   = 1'b0;
      do_class   = 1'b0;
      pend       = 6'd0;

      if (!halt_ff) begin
         case (mode_ff)
            MODE_STR: begin
               if (b == CHAR_QUOTE) begin
                  bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_STRING);
                  bundle.count = bundle.count + 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
                  bundle.count = bundle.count + 1'b1;
               end
            end
            MODE_EQ, MODE_BANG: begin
               if (b == "=") begin
                  bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
                  bundle.count = bundle.count + 1'b1;
                  bundle.item[bundle.count[SLOT_W-1:0]] =
                     mk_end((mode_ff == MODE_EQ) ? TOK_EQUAL : TOK_NOT_EQUAL);
                  bundle.count = bundle.count + 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  do_close = 1'b1;
                  do_class = 1'b1;
               end
            end
            MODE_INT: begin
               if (b inside {["0":"9"]}) begin
                  bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
                  bundle.count = bundle.count + 1'b1;
               end else begin
                  do_close = 1'b1;
                  do_class = 1'b1;
               end
            end
            MODE_KW: begin
               if (b inside {["A":"Z"]}) begin
                  if (len_ff < 4'(MAX_KEYWORD_LEN)) begin
                     for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
                        if (len_ff == 4'(i)) begin
                           letters_in[8*i +: 8] = b;
                        end
                     end
                     len_in = len_ff + 4'd1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
                  bundle.count = bundle.count + 1'b1;
               end else begin
                  do_close = 1'b1;
                  do_class = 1'b1;
               end
            end
            MODE_ID: begin
               if ((b inside {["A":"Z"], ["a":"z"]}) || (b == "_")) begin
                  bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
                  bundle.count = bundle.count + 1'b1;
               end else begin
                  do_close = 1'b1;
                  do_class = 1'b1;
               end
            end
            default: begin
               mode_in  = MODE_IDLE;
               do_class = 1'b1;
            end
         endcase
      end

      // Close the token that the byte terminated.
      if (do_close) begin
         pend = pend_of(mode_in, letters_in, len_in, ovf_in);
         if (pend[5]) begin
            bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(pend[4:0]);
            bundle.count = bundle.count + 1'b1;
         end
         if (mode_in == MODE_KW) begin
            letters_in = '0;
            len_in     = 4'd0;
            ovf_in     = 1'b0;
         end
         mode_in = MODE_IDLE;
      end

      // Classify the byte from the idle state.
      if (do_class) begin
         case (b)
            "(", ")", ">", "<", "+", "-", "*", "/", ",": begin
               bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
               bundle.count = bundle.count + 1'b1;
               case (b)
                  "(":     bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_OPEN_PAREN);
                  ")":     bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_CLOSE_PAREN);
                  ">":     bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_GREATER);
                  "<":     bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_LESS);
                  "+":     bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_ADD);
                  "-":     bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_SUBTRACT);
                  "*":     bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_MULTIPLY);
                  "/":     bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_DIVIDE);
                  default: bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(TOK_COMMA);
               endcase
               bundle.count = bundle.count + 1'b1;
            end
            "=", "!": begin
               bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
               bundle.count = bundle.count + 1'b1;
               mode_in = (b == "=") ? MODE_EQ : MODE_BANG;
            end
            CHAR_QUOTE: begin
               mode_in = MODE_STR;
            end
            default: begin
               if ((b == 8'd0) || b[7]) begin
                  halt_in = 1'b1;
               end else if (b inside {["0":"9"]}) begin
                  bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
                  bundle.count = bundle.count + 1'b1;
                  mode_in = MODE_INT;
               end else if (b inside {["A":"Z"]}) begin
                  letters_in         = '0;
                  letters_in[7:0]    = b;
                  len_in             = 4'd1;
                  ovf_in             = 1'b0;
                  bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
                  bundle.count = bundle.count + 1'b1;
                  mode_in = MODE_KW;
               end else if (b inside {["a":"z"]}) begin
                  bundle.item[bundle.count[SLOT_W-1:0]] = mk_text(b);
                  bundle.count = bundle.count + 1'b1;
                  mode_in = MODE_ID;
               end
            end
         endcase
      end

      // Last byte: close what is open unless halted, then return to the reset state.
      if (req_data.end_of_text) begin
         if (!halt_in) begin
            pend = pend_of(mode_in, letters_in, len_in, ovf_in);
            if (pend[5]) begin
               bundle.item[bundle.count[SLOT_W-1:0]] = mk_end(pend[4:0]);
               bundle.count = bundle.count + 1'b1;
            end
         end
         mode_in    = MODE_IDLE;
         letters_in = '0;
         len_in     = 4'd0;
         ovf_in     = 1'b0;
         halt_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         letters_ff <= '0;
         len_ff     <= 4'd0;
         ovf_ff     <= 1'b0;
         halt_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         letters_ff <= letters_in;
         len_ff     <= len_in;
         ovf_ff     <= ovf_in;
         halt_ff    <= halt_in;
      end
   end

endmodule

>>> rtl/core/stt_queue.sv
// Short bundle queue between the tokenizer front and back ends.
// Depends on stt_pkg for the bundle type and depth.
module stt_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  stt_pkg::stt_bundle_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output stt_pkg::stt_bundle_type out_data
);
   import stt_pkg::*;

   stt_bundle_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/stt_back.sv
// Back end of the tokenizer: walks the slots of the head bundle and drives
// the result channel through an output register. Depends on stt_pkg.
module stt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   output logic                    head_pop,
   input  stt_pkg::stt_bundle_type head_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output stt_pkg::stt_rsp_type    rsp_data
);
   import stt_pkg::*;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              rsp_valid_ff, rsp_valid_in;
   stt_rsp_type       rsp_data_ff, rsp_data_in;
   logic              load, last_slot;

   assign load      = head_valid && (!rsp_valid_ff || rsp_ready);
   assign last_slot = (COUNT_W'(slot_ff) + 1'b1) == head_data.count;
   assign head_pop  = load && last_slot;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = head_data.item[slot_ff];
         slot_in      = last_slot ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/source_text_tokenizer.sv
// Source text tokenizer, top level: front end, bundle queue and back end.
// Depends on stt_pkg, stt_front, stt_queue and stt_back.
//
// Source bytes enter one per transfer on the req_ channel; each accepted byte
// produces zero to three results on the rsp_ channel: token text bytes, then
// a token-end result that carries the token type. The front end classifies a
// byte in the cycle it arrives and writes all of that byte's results as one
// bundle into a four-entry queue; the back end hands the bundle's results out
// one per cycle through an output register while rsp_ready is high.
// A byte is accepted every cycle while the queue has a free entry, so the
// input rate is one byte per cycle; the output side drains one result per
// cycle, which sets the sustained rate (a byte closing one token and opening
// a one-byte token yields three results). The first result of a byte passes
// through a queue entry and then the output register before it reaches rsp_.
// A zero byte or one of 128 and above outside a string stops all output until
// a byte with end_of_text set arrives, which closes any open token and returns
// the block to its reset state.
module source_text_tokenizer #(
   parameter int unsigned MAX_KEYWORD_LEN = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stt_pkg::stt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stt_pkg::stt_rsp_type rsp_data
);
   import stt_pkg::*;

   // Front to queue: one bundle per byte that yields any result.
   logic           push_valid, push_ready;
   stt_bundle_type push_data;

   // Queue to back end: head bundle, popped after its last slot goes out.
   logic           head_valid, head_pop;
   stt_bundle_type head_data;

   stt_front #(
      .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (head_valid),
      .out_ready (head_pop),
      .out_data  (head_data)
   );

   stt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_data  (head_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> test/source_text_tokenizer_test.sv
// Self-checking bench for source_text_tokenizer: random source text with a token predictor.
// Depends on stt_pkg and the source_text_tokenizer RTL only.
module source_text_tokenizer_test;
   import stt_pkg::*;

   localparam int unsigned KEYWORD_LIMIT = 8;
   localparam int unsigned RANDOM_ITEMS  = 260;
   localparam int unsigned LIMIT_CYCLES  = 150000;
   localparam int unsigned HOLD_CYCLES   = 80;
   localparam int unsigned TAIL_CYCLES   = 30;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_AFTER_EQ,
      SCAN_AFTER_BANG,
      SCAN_STRING,
      SCAN_INT,
      SCAN_KEYWORD,
      SCAN_IDENT
   } scan_mode_type;

   // Token predictor plus the queue of results it owes the output side.
   class token_scoreboard;
      scan_mode_type  mode;
      logic [63:0]    kw_word;    // letters shift in at the low byte, so the last letter is lowest
      int unsigned    kw_count;
      bit             kw_over;
      bit             stopped;
      stt_rsp_type    token_results_due[$];
      int unsigned    checked;
      int unsigned    tokens;
      int unsigned    halts;
      int unsigned    errors;

      function new();
         mode     = SCAN_IDLE;
         kw_word  = '0;
         kw_count = 0;
         kw_over  = 1'b0;
         stopped  = 1'b0;
      endfunction

      function int unsigned pending();
         return token_results_due.size();
      endfunction

      function bit is_upper(logic [7:0] b);
         return b >= "A" && b <= "Z";
      endfunction

      function bit is_lower(logic [7:0] b);
         return b >= "a" && b <= "z";
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      function void push_text(logic [7:0] b);
         stt_rsp_type r;
         r.token_type = '0;
         r.text_byte  = b;
         r.token_end  = 1'b0;
         token_results_due = {token_results_due, r};
      endfunction

      function void push_end(tok_kind_type kind);
         stt_rsp_type r;
         r.token_type = kind;
         r.text_byte  = '0;
         r.token_end  = 1'b1;
         token_results_due = {token_results_due, r};
      endfunction

      function void clear_word();
         kw_word  = '0;
         kw_count = 0;
         kw_over  = 1'b0;
      endfunction

      function void add_letter(logic [7:0] b);
         if (kw_count < KEYWORD_LIMIT) begin
            kw_word = {kw_word[55:0], b};
            kw_count++;
         end else begin
            kw_over = 1'b1;
         end
      endfunction

      function tok_kind_type keyword_kind();
         if (kw_over) return TOK_UNKNOWN_KW;
         if (kw_word == "FUNCTION") return TOK_KW_FUNCTION;
         if (kw_word == "VARIABLE") return TOK_KW_VARIABLE;
         if (kw_word == "END") return TOK_KW_END;
         if (kw_word == "IF") return TOK_KW_IF;
         if (kw_word == "RETURN") return TOK_KW_RETURN;
         if (kw_word == "PRINT") return TOK_KW_PRINT;
         return TOK_UNKNOWN_KW;
      endfunction

      function void single(logic [7:0] b, tok_kind_type kind);
         push_text(b);
         push_end(kind);
      endfunction

      // Start a token from idle, or skip / stop on the byte.
      function void classify(logic [7:0] b);
         case (b)
            "(": single(b, TOK_OPEN_PAREN);
            ")": single(b, TOK_CLOSE_PAREN);
            ">": single(b, TOK_GREATER);
            "<": single(b, TOK_LESS);
            "+": single(b, TOK_ADD);
            "-": single(b, TOK_SUBTRACT);
            "*": single(b, TOK_MULTIPLY);
            "/": single(b, TOK_DIVIDE);
            ",": single(b, TOK_COMMA);
            "=": begin
               push_text(b);
               mode = SCAN_AFTER_EQ;
            end
            "!": begin
               push_text(b);
               mode = SCAN_AFTER_BANG;
            end
            CHAR_QUOTE: mode = SCAN_STRING;
            default: begin
               if (b == 8'h00 || b[7]) begin
                  stopped = 1'b1;
                  halts++;
               end else if (is_digit(b)) begin
                  push_text(b);
                  mode = SCAN_INT;
               end else if (is_upper(b)) begin
                  clear_word();
                  add_letter(b);
                  push_text(b);
                  mode = SCAN_KEYWORD;
               end else if (is_lower(b)) begin
                  push_text(b);
                  mode = SCAN_IDENT;
               end
            end
         endcase
      endfunction

      function void close_open();
         case (mode)
            SCAN_AFTER_EQ:   push_end(TOK_ASSIGN);
            SCAN_AFTER_BANG: push_end(TOK_NOT);
            SCAN_STRING:     push_end(TOK_STRING);
            SCAN_INT:        push_end(TOK_INT);
            SCAN_KEYWORD: begin
               push_end(keyword_kind());
               clear_word();
            end
            SCAN_IDENT:      push_end(TOK_IDENT);
            default: ;
         endcase
         mode = SCAN_IDLE;
      endfunction

      // Note one accepted byte; returns 1 when the byte did more than get skipped.
      function bit note_byte(stt_req_type item);
         logic [7:0]    b;
         bit            goes_on;
         int unsigned   due_before;
         scan_mode_type mode_before;
         bit            stop_before;
         b           = item.source_byte;
         goes_on     = 1'b0;
         due_before  = token_results_due.size();
         mode_before = mode;
         stop_before = stopped;
         if (!stopped) begin
            case (mode)
               SCAN_STRING: begin
                  goes_on = 1'b1;
                  if (b == CHAR_QUOTE) begin
                     push_end(TOK_STRING);
                     mode = SCAN_IDLE;
                  end else begin
                     push_text(b);
                  end
               end
               SCAN_AFTER_EQ, SCAN_AFTER_BANG: begin
                  if (b == "=") begin
                     goes_on = 1'b1;
                     push_text(b);
                     push_end(mode == SCAN_AFTER_EQ ? TOK_EQUAL : TOK_NOT_EQUAL);
                     mode = SCAN_IDLE;
                  end
               end
               SCAN_INT: begin
                  if (is_digit(b)) begin
                     goes_on = 1'b1;
                     push_text(b);
                  end
               end
               SCAN_KEYWORD: begin
                  if (is_upper(b)) begin
                     goes_on = 1'b1;
                     add_letter(b);
                     push_text(b);
                  end
               end
               SCAN_IDENT: begin
                  if (is_upper(b) || is_lower(b) || b == "_") begin
                     goes_on = 1'b1;
                     push_text(b);
                  end
               end
               default: ;
            endcase
            if (!goes_on) begin
               close_open();
               classify(b);
            end
         end
         if (item.end_of_text) begin
            if (!stopped) close_open();
            mode    = SCAN_IDLE;
            clear_word();
            stopped = 1'b0;
         end
         return token_results_due.size() != due_before || mode != mode_before ||
                stopped != stop_before || item.end_of_text;
      endfunction

      function void check_result(stt_rsp_type got);
         stt_rsp_type want;
         if (token_results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result type=%0d text=%02h end=%0b, nothing pending",
                     $time, got.token_type, got.text_byte, got.token_end);
            return;
         end
         want = token_results_due.pop_front();
         checked++;
         if (got.token_end === 1'b1) tokens++;
         if (got.token_type !== want.token_type || got.text_byte !== want.text_byte ||
             got.token_end !== want.token_end) begin
            errors++;
            $display("%0t: result mismatch: expected type=%0d text=%02h end=%0b,",
                     $time, want.token_type, want.text_byte, want.token_end);
            $display("%0t:   got type=%0d text=%02h end=%0b",
                     $time, got.token_type, got.text_byte, got.token_end);
         end
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   stt_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   stt_rsp_type rsp_data;

   token_scoreboard board;
   bit              steady       = 1'b0;  // no idling on either side while set
   int unsigned     hold_request = 0;
   int unsigned     hold_left    = 0;
   int unsigned     counted      = 0;
   int unsigned     sent         = 0;
   int unsigned     text_ends    = 0;
   int unsigned     cycles       = 0;

   source_text_tokenizer #(
      .MAX_KEYWORD_LEN(KEYWORD_LIMIT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // Idle with a chance of 28 in a hundred, except during the steady stretch.
   function automatic bit take_gap();
      return !steady && ($urandom_range(99) < 28);
   endfunction

   // Watchdog: end the run if the traffic never drains.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d results still due", cycles, board.pending());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side: check each transfer seen at this edge, then pick ready for the next.
   // A hold-off request blocks the output for a counted stretch so the queue fills.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !take_gap();
      end
   end

   // Offer one byte and hold it until the transfer; valid stays high into the next
   // byte unless a gap is taken, so it is never dropped and raised in one step.
   task automatic send_byte(input logic [7:0] value, input logic last);
      stt_req_type item;
      item.source_byte = value;
      item.end_of_text = last;
      while (take_gap()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (board.note_byte(item)) counted++;
      sent++;
      if (last) text_ends++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   // Drop valid and hold the input until every predicted result has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Build one random token, mostly well formed, sometimes noise or a stop byte.
   task automatic send_random_token();
      logic [7:0] seq[$];
      logic [7:0] b;
      string      word;
      int         kind;
      int         r;
      bit         last_ends;
      kind      = int'($urandom_range(99));
      last_ends = ($urandom_range(24) == 0);
      if (kind < 14) begin
         case ($urandom_range(5))
            0: word = "FUNCTION";
            1: word = "VARIABLE";
            2: word = "END";
            3: word = "IF";
            4: word = "RETURN";
            default: word = "PRINT";
         endcase
         for (int i = 0; i < word.len(); i++) seq = {seq, word[i]};
      end else if (kind < 22) begin
         // uppercase run, sometimes past the keyword buffer
         repeat ($urandom_range(1, 11)) seq = {seq, 8'($urandom_range("A", "Z"))};
      end else if (kind < 34) begin
         seq = {seq, 8'($urandom_range("a", "z"))};
         repeat ($urandom_range(0, 5)) begin
            r = int'($urandom_range(52));
            if (r == 52) b = "_";
            else if (r < 26) b = 8'("a" + r);
            else b = 8'("A" + r - 26);
            seq = {seq, b};
         end
      end else if (kind < 44) begin
         repeat ($urandom_range(1, 5)) seq = {seq, 8'($urandom_range("0", "9"))};
      end else if (kind < 54) begin
         // string body takes any byte, stop bytes included; leave some unclosed
         seq = {seq, CHAR_QUOTE};
         repeat ($urandom_range(0, 5)) begin
            do b = 8'($urandom_range(255)); while (b == CHAR_QUOTE);
            seq = {seq, b};
         end
         if ($urandom_range(9) != 0) seq = {seq, CHAR_QUOTE};
      end else if (kind < 74) begin
         word = "()<>+-*/,=!";
         b    = word[$urandom_range(word.len() - 1)];
         seq = {seq, b};
         if ((b == "=" || b == "!") && $urandom_range(1)) seq = {seq, 8'("=")};
      end else if (kind < 86) begin
         // space, or one of tab, LF, VT, FF, CR
         b = 8'($urandom_range(8, 13));
         seq = {seq, (b == 8) ? 8'h20 : b};
      end else if (kind < 94) begin
         seq = {seq, 8'($urandom_range(1, 127))};
      end else begin
         // stop byte, some ignored bytes, then end of text to recover
         seq = {seq, $urandom_range(1) ? 8'h00 : 8'($urandom_range(128, 255))};
         repeat ($urandom_range(0, 2)) seq = {seq, 8'($urandom_range(255))};
         last_ends = 1'b1;
      end
      foreach (seq[i]) send_byte(seq[i], last_ends && i == seq.size() - 1);
   endtask

   initial begin
      bit held;
      bit drained;
      board   = new();
      held    = 1'b0;
      drained = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: every single-character token, == and !=, a bare ! and =,
      // a string, a keyword closed by a digit, a stop byte closing an integer,
      // then a high byte with end of text while stopped.
      send_text("()<>+-*/,==!=!x=\"a\"IF9");
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);

      while (sent < RANDOM_ITEMS) begin
         steady = (sent >= 90 && sent < 140);
         if (!held && sent >= 170) begin
            held         = 1'b1;
            hold_request = HOLD_CYCLES;
         end
         if (!drained && sent >= 215) begin
            drained = 1'b1;
            wait_for_drain();
         end
         send_random_token();
      end
      steady = 1'b0;

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d source bytes (%0d not skipped, %0d text ends, %0d stop bytes)",
               sent, counted, text_ends, board.halts);
      $display("and %0d results in %0d tokens", board.checked, board.tokens);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d errors, %0d results never arrived", board.errors, board.pending());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> source_text_tokenizer.f
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_queue.sv
rtl/core/stt_back.sv
rtl/core/source_text_tokenizer.sv
test/source_text_tokenizer_test.sv
